// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the downmix block.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: sv/sdbl_pkg.sv
// Package for the stereo downmix low-pass block: types, codes and helpers.
// Used by the register bank, controller, datapath and top level; no dependencies.
package sdbl_pkg;

    localparam logic [1:0] MODE_STEREO = 2'd0;
    localparam logic [1:0] MODE_MONO   = 2'd1;

    typedef enum logic [2:0] {
        CFG_MODE,
        CFG_S1_B1,
        CFG_S1_A1,
        CFG_S1_A2,
        CFG_S2_B1,
        CFG_S2_A1,
        CFG_S2_A2
    } cfg_idx_t;

    localparam logic [1:0]         RST_MODE  = 2'd2;
    localparam logic signed [31:0] RST_S1_B1 = 32'sd139528187;
    localparam logic signed [31:0] RST_S1_A1 = 32'sd0;
    localparam logic signed [31:0] RST_S1_A2 = 32'sd10620917;
    localparam logic signed [31:0] RST_S2_B1 = 32'sd194140843;
    localparam logic signed [31:0] RST_S2_A1 = 32'sd0;
    localparam logic signed [31:0] RST_S2_A2 = 32'sd119846499;

    localparam logic signed [67:0] ACC_RND = 68'sh10000000;

    typedef struct packed {
        logic signed [31:0] s1_b1;
        logic signed [31:0] s1_a1;
        logic signed [31:0] s1_a2;
        logic signed [31:0] s2_b1;
        logic signed [31:0] s2_a1;
        logic signed [31:0] s2_a2;
    } coef_t;

    typedef enum logic [3:0] {
        T_S1_X,
        T_S1_X1,
        T_S1_X2,
        T_S1_Y1,
        T_S1_Y2,
        T_S2_X,
        T_S2_X1,
        T_S2_X2,
        T_S2_Y1,
        T_S2_Y2
    } term_t;

    typedef enum logic [1:0] {
        OUT_LEFT,
        OUT_RIGHT,
        OUT_MONO,
        OUT_FILT
    } out_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        term_t    term;
        logic     latch_y1;
        logic     latch_y2;
        logic     out_load;
        out_sel_t out_sel;
    } cmd_t;

    // Drop the 29 fraction bits of the accumulator and saturate to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [67:0] acc);
        logic signed [38:0] sh;
        logic signed [31:0] res;
        sh = acc[67:29];
        if (!sh[38] && (|sh[37:31])) begin
            res = 32'sh7FFFFFFF;
        end else if (sh[38] && !(&sh[37:31])) begin
            res = 32'sh80000000;
        end else begin
            res = sh[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clip16(input logic signed [20:0] v);
        logic signed [15:0] res;
        if (v > 21'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -21'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

// File: sv/sdbl_cfg.sv
// Configuration register bank: mode and the six biquad coefficients.
// Depends on sdbl_pkg for register indexes, reset values and the coef_t type.
module sdbl_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic [1:0]          mode,
    output sdbl_pkg::coef_t     coef
);
    import sdbl_pkg::*;

    logic [1:0] mode_reg;
    coef_t      coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= RST_MODE;
            coef_reg.s1_b1 <= RST_S1_B1;
            coef_reg.s1_a1 <= RST_S1_A1;
            coef_reg.s1_a2 <= RST_S1_A2;
            coef_reg.s2_b1 <= RST_S2_B1;
            coef_reg.s2_a1 <= RST_S2_A1;
            coef_reg.s2_a2 <= RST_S2_A2;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MODE:  mode_reg       <= cfg_data[1:0];
                CFG_S1_B1: coef_reg.s1_b1 <= cfg_data;
                CFG_S1_A1: coef_reg.s1_a1 <= cfg_data;
                CFG_S1_A2: coef_reg.s1_a2 <= cfg_data;
                CFG_S2_B1: coef_reg.s2_b1 <= cfg_data;
                CFG_S2_A1: coef_reg.s2_a1 <= cfg_data;
                CFG_S2_A2: coef_reg.s2_a2 <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign mode = mode_reg;
    assign coef = coef_reg;

endmodule

// File: sv/sdbl_ctrl.sv
// Controller state machine: accepts a frame, steps the shared multiply-accumulate
// sequence and loads the output register. Depends on sdbl_pkg for cmd_t and codes.
module sdbl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [1:0]     mode,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output sdbl_pkg::cmd_t cmd
);
    import sdbl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_EMIT_L,
        ST_EMIT_R,
        ST_EMIT_M
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       can_load;

    assign can_load = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        cmd.term       = T_S1_X;
        cmd.out_sel    = OUT_LEFT;
        state_next     = state_reg;
        step_next      = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_in = in_valid;
                step_next   = 4'd0;
                if (in_valid)
                begin
                    if (mode == MODE_STEREO)
                        state_next = ST_EMIT_L;
                    else if (mode == MODE_MONO)
                        state_next = ST_EMIT_M;
                    else
                        state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                step_next = step_reg + 4'd1;
                case (step_reg)
                    4'd0:    begin cmd.mul_en = 1'b1; cmd.term = T_S1_X;  end
                    4'd1:    begin cmd.mul_en = 1'b1; cmd.term = T_S1_X1; end
                    4'd2:    begin cmd.mul_en = 1'b1; cmd.term = T_S1_X2; end
                    4'd3:    begin cmd.mul_en = 1'b1; cmd.term = T_S1_Y1; end
                    4'd4:    begin cmd.mul_en = 1'b1; cmd.term = T_S1_Y2; end
                    4'd6:    cmd.latch_y1 = 1'b1;
                    4'd7:    begin cmd.mul_en = 1'b1; cmd.term = T_S2_X;  end
                    4'd8:    begin cmd.mul_en = 1'b1; cmd.term = T_S2_X1; end
                    4'd9:    begin cmd.mul_en = 1'b1; cmd.term = T_S2_X2; end
                    4'd10:   begin cmd.mul_en = 1'b1; cmd.term = T_S2_Y1; end
                    4'd11:   begin cmd.mul_en = 1'b1; cmd.term = T_S2_Y2; end
                    4'd13:
                    begin
                        cmd.latch_y2 = 1'b1;
                        state_next   = ST_EMIT_M;
                    end
                    default: ;
                endcase
            end
            ST_EMIT_L:
            begin
                cmd.out_sel  = OUT_LEFT;
                cmd.out_load = can_load;
                if (can_load)
                    state_next = ST_EMIT_R;
            end
            ST_EMIT_R:
            begin
                cmd.out_sel  = OUT_RIGHT;
                cmd.out_load = can_load;
                if (can_load)
                    state_next = ST_IDLE;
            end
            ST_EMIT_M:
            begin
                cmd.out_sel  = (mode == MODE_MONO) ? OUT_MONO : OUT_FILT;
                cmd.out_load = can_load;
                if (can_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: sv/sdbl_dp.sv
// Datapath: sample registers, filter history, one 32x32 multiplier feeding a
// 68-bit accumulator, and the output register. Depends on sdbl_pkg.
module sdbl_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  sdbl_pkg::cmd_t      cmd,
    input  sdbl_pkg::coef_t     coef,
    input  logic signed [15:0]  left_sample,
    input  logic signed [15:0]  right_sample,
    output logic signed [15:0]  out_sample,
    output logic                last_of_frame
);
    import sdbl_pkg::*;

    logic signed [15:0] left_reg, right_reg;
    logic signed [31:0] x1_reg, x1_next, x2_reg, x2_next;
    logic signed [31:0] u1_reg, u1_next, u2_reg, u2_next;
    logic signed [31:0] v1_reg, v1_next, v2_reg, v2_next;
    logic signed [31:0] y1_reg, y2_reg;
    logic signed [63:0] prod_reg, prod_next;
    logic               pv_reg, pv_next;
    logic               pshift_reg, pneg_reg, pfirst_reg;
    logic signed [67:0] acc_reg, acc_next;
    logic signed [15:0] out_sample_reg, out_sample_next;
    logic               last_reg;

    logic signed [16:0] sum;
    logic signed [31:0] x_cur;
    logic signed [31:0] opa, opb;
    logic               t_shift, t_neg, t_first;
    logic signed [67:0] term_ext, term_sh, base;
    logic signed [31:0] y_sat;
    logic signed [17:0] sum18, mono18;
    logic signed [32:0] y33, r33;

    assign sum   = 17'(left_reg) + 17'(right_reg);
    assign x_cur = {{4{sum[16]}}, sum, 11'b0};

    always_comb
    begin
        opa     = coef.s1_b1;
        opb     = x_cur;
        t_shift = 1'b0;
        t_neg   = 1'b0;
        t_first = 1'b0;
        case (cmd.term)
            T_S1_X:  begin opa = coef.s1_b1; opb = x_cur;  t_first = 1'b1; end
            T_S1_X1: begin opa = coef.s1_b1; opb = x1_reg; t_shift = 1'b1; end
            T_S1_X2: begin opa = coef.s1_b1; opb = x2_reg; end
            T_S1_Y1: begin opa = coef.s1_a1; opb = u1_reg; t_shift = 1'b1; t_neg = 1'b1; end
            T_S1_Y2: begin opa = coef.s1_a2; opb = u2_reg; t_shift = 1'b1; t_neg = 1'b1; end
            T_S2_X:  begin opa = coef.s2_b1; opb = y1_reg; t_first = 1'b1; end
            T_S2_X1: begin opa = coef.s2_b1; opb = u1_reg; t_shift = 1'b1; end
            T_S2_X2: begin opa = coef.s2_b1; opb = u2_reg; end
            T_S2_Y1: begin opa = coef.s2_a1; opb = v1_reg; t_shift = 1'b1; t_neg = 1'b1; end
            T_S2_Y2: begin opa = coef.s2_a2; opb = v2_reg; t_shift = 1'b1; t_neg = 1'b1; end
            default: ;
        endcase
    end

    assign prod_next = opa * opb;
    assign pv_next   = cmd.mul_en;

    assign term_ext = {{4{prod_reg[63]}}, prod_reg};
    assign term_sh  = pshift_reg ? (term_ext <<< 1) : term_ext;
    assign base     = pfirst_reg ? ACC_RND : acc_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (pv_reg)
            acc_next = pneg_reg ? (base - term_sh) : (base + term_sh);
    end

    assign y_sat = sat32(acc_reg);

    always_comb
    begin
        x1_next = x1_reg;
        x2_next = x2_reg;
        u1_next = u1_reg;
        u2_next = u2_reg;
        v1_next = v1_reg;
        v2_next = v2_reg;
        if (cmd.latch_y2)
        begin
            x2_next = x1_reg;
            x1_next = x_cur;
            u2_next = u1_reg;
            u1_next = y1_reg;
            v2_next = v1_reg;
            v1_next = y_sat;
        end
    end

    assign sum18  = {sum[16], sum};
    assign mono18 = sum[16] ? (sum18 >>> 1) : ((sum18 + 18'sd1) >>> 1);
    assign y33    = {y2_reg[31], y2_reg};
    assign r33    = y2_reg[31] ? (y33 + 33'sd2047) : (y33 + 33'sd2048);

    always_comb
    begin
        case (cmd.out_sel)
            OUT_LEFT:  out_sample_next = left_reg;
            OUT_RIGHT: out_sample_next = right_reg;
            OUT_MONO:  out_sample_next = mono18[15:0];
            OUT_FILT:  out_sample_next = clip16(r33[32:12]);
            default:   out_sample_next = left_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            u1_reg <= '0;
            u2_reg <= '0;
            v1_reg <= '0;
            v2_reg <= '0;
            pv_reg <= 1'b0;
        end
        else
        begin
            x1_reg <= x1_next;
            x2_reg <= x2_next;
            u1_reg <= u1_next;
            u2_reg <= u2_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            pv_reg <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            left_reg  <= left_sample;
            right_reg <= right_sample;
        end
        prod_reg   <= prod_next;
        pshift_reg <= t_shift;
        pneg_reg   <= t_neg;
        pfirst_reg <= t_first;
        acc_reg    <= acc_next;
        if (cmd.latch_y1)
            y1_reg <= y_sat;
        if (cmd.latch_y2)
            y2_reg <= y_sat;
        if (cmd.out_load)
        begin
            out_sample_reg <= out_sample_next;
            last_reg       <= (cmd.out_sel != OUT_LEFT);
        end
    end

    assign out_sample    = out_sample_reg;
    assign last_of_frame = last_reg;

endmodule

// File: sv/stereo_downmix_butterworth_lowpass.sv
// Stereo downmix with a fourth-order Butterworth low-pass; takes one frame per
// transaction. Stereo mode steps through accept, left and right; mono mode through
// accept and one output. In filtered mode ten products of two biquads go in turn
// through one 32x32 multiplier and accumulator, and the second section waits for
// the first one's rounded output. A pending result does not hold off the next
// frame's computation. There is no clearing pass; the history resets at once.
// Depends on sdbl_pkg, sdbl_cfg, sdbl_ctrl, sdbl_dp and assert_macros.svh.
`include "assert_macros.svh"

module stereo_downmix_butterworth_lowpass (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] left_sample,
    input  logic signed [15:0] right_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_sample,
    output logic               last_of_frame,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import sdbl_pkg::*;

    logic [1:0] mode;
    coef_t      coef;
    cmd_t       cmd;

    assign cfg_ready = 1'b1;

    sdbl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mode      (mode),
        .coef      (coef)
    );

    sdbl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    sdbl_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .coef          (coef),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .out_sample    (out_sample),
        .last_of_frame (last_of_frame)
    );

    // A frame is worked on alone; a new result never overwrites one not yet taken.
    `ASSERT_NEXT(a_one_frame, in_valid && in_ready, !in_ready)
    `ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid || out_ready)
    `ASSERT_SAME(a_frame_open, out_valid && out_ready && !last_of_frame, !in_ready)

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for stereo_downmix_butterworth_lowpass: stereo, mono and filtered
// frames, with expected samples from an internal model of the two-biquad low-pass.
// Depends on sdbl_pkg and the RTL of the block; needs no files or arguments.
module tb_top;

    import sdbl_pkg::*;

    localparam logic [1:0] MODE_LOWPASS       = 2'd2;
    localparam logic [1:0] MODE_LOWPASS_ALIAS = 2'd3;
    localparam logic [2:0] CFG_NONE           = 3'd7;

    localparam logic signed [31:0] DEF_S1_B1 = 32'sd139528187;
    localparam logic signed [31:0] DEF_S1_A1 = 32'sd0;
    localparam logic signed [31:0] DEF_S1_A2 = 32'sd10620917;
    localparam logic signed [31:0] DEF_S2_B1 = 32'sd194140843;
    localparam logic signed [31:0] DEF_S2_A1 = 32'sd0;
    localparam logic signed [31:0] DEF_S2_A2 = 32'sd119846499;

    localparam logic signed [71:0] ACC_HALF_LSB = 72'sd268435456;
    localparam logic signed [71:0] Q12_MAX      = 72'sd2147483647;
    localparam logic signed [71:0] Q12_MIN      = -72'sd2147483648;

    localparam int N_ROWS         = 18;
    localparam int N_PHASES       = 12;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;

    typedef enum int {
        COEF_DEFAULT,
        COEF_RANDOM,
        COEF_MAX,
        COEF_MIN,
        COEF_SMALL,
        COEF_ZERO
    } coef_kind_t;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
    } pcm_result_t;

    typedef struct {
        logic [1:0]         mode;
        logic signed [15:0] l_pcm;
        logic signed [15:0] r_pcm;
        bit                 typed;
        logic signed [15:0] want_first;
        logic signed [15:0] want_second;
    } frame_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] out_sample;
    logic               last_of_frame;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    logic [1:0]         model_mode;
    coef_t              model_coef;
    logic signed [31:0] s1_x_hist [2];
    logic signed [31:0] s1_y_hist [2];
    logic signed [31:0] s2_y_hist [2];

    pcm_result_t pending_pcm [$];
    int          mismatches;
    int          idle_odds;
    int          quiet_cycles;

    stereo_downmix_butterworth_lowpass dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_sample    (out_sample),
        .last_of_frame (last_of_frame),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [31:0] biquad_section(
        input logic signed [31:0] b1, a1, a2, x, x1, x2, y1, y2);
        logic signed [71:0] acc;
        logic signed [71:0] q;
        acc = b1 * x + 2 * b1 * x1 + b1 * x2 - 2 * a1 * y1 - 2 * a2 * y2 + ACC_HALF_LSB;
        q = acc >>> 29;
        if (q > Q12_MAX)
        begin
            q = Q12_MAX;
        end
        else if (q < Q12_MIN)
        begin
            q = Q12_MIN;
        end
        return q[31:0];
    endfunction

    function automatic logic signed [15:0] clamp_pcm(input longint v);
        logic signed [15:0] res;
        if (v > 32767)
        begin
            res = 16'sh7FFF;
        end
        else if (v < -32768)
        begin
            res = 16'sh8000;
        end
        else
        begin
            res = 16'(v);
        end
        return res;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            CFG_MODE:  model_mode = val[1:0];
            CFG_S1_B1: model_coef.s1_b1 = val;
            CFG_S1_A1: model_coef.s1_a1 = val;
            CFG_S1_A2: model_coef.s1_a2 = val;
            CFG_S2_B1: model_coef.s2_b1 = val;
            CFG_S2_A1: model_coef.s2_a1 = val;
            CFG_S2_A2: model_coef.s2_a2 = val;
            default: ;
        endcase
    endfunction

    function automatic void predict_downmix(input logic signed [15:0] l, r,
                                            output pcm_result_t res [2], output int count);
        longint             sum;
        longint             avg;
        longint             yl;
        logic signed [31:0] x;
        logic signed [31:0] y1;
        logic signed [31:0] y2;
        sum = longint'(l) + longint'(r);
        res[1] = '{16'sd0, 1'b0};
        if (model_mode == MODE_STEREO)
        begin
            res[0] = '{l, 1'b0};
            res[1] = '{r, 1'b1};
            count = 2;
        end
        else
        begin
            if (model_mode == MODE_MONO)
            begin
                avg = (sum >= 0) ? (sum + 1) / 2 : -((-sum + 1) / 2);
            end
            else
            begin
                x = 32'(sum * 2048);
                y1 = biquad_section(model_coef.s1_b1, model_coef.s1_a1, model_coef.s1_a2,
                                    x, s1_x_hist[0], s1_x_hist[1], s1_y_hist[0], s1_y_hist[1]);
                y2 = biquad_section(model_coef.s2_b1, model_coef.s2_a1, model_coef.s2_a2,
                                    y1, s1_y_hist[0], s1_y_hist[1], s2_y_hist[0], s2_y_hist[1]);
                s1_x_hist[1] = s1_x_hist[0];
                s1_x_hist[0] = x;
                s1_y_hist[1] = s1_y_hist[0];
                s1_y_hist[0] = y1;
                s2_y_hist[1] = s2_y_hist[0];
                s2_y_hist[0] = y2;
                yl = longint'(y2);
                avg = (yl >= 0) ? (yl + 2048) / 4096 : -((-yl + 2048) / 4096);
            end
            res[0] = '{clamp_pcm(avg), 1'b1};
            count = 1;
        end
    endfunction

    function automatic logic [31:0] pick_coef(input coef_kind_t kind, input logic [31:0] dflt);
        logic [31:0] v;
        case (kind)
            COEF_DEFAULT: v = dflt;
            COEF_RANDOM:  v = $urandom();
            COEF_MAX:     v = 32'h7FFF_FFFF;
            COEF_MIN:     v = 32'h8000_0000;
            COEF_SMALL:   v = 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
            default:      v = 32'h0;
        endcase
        return v;
    endfunction

    // A register write completes on its transaction; cfg_valid is left high for the caller.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, val);
    endtask

    task automatic send_frame(input logic signed [15:0] l, r, input bit typed,
                              input logic signed [15:0] want_first, want_second);
        int          gap;
        int          count;
        pcm_result_t res [2];
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        left_sample <= l;
        right_sample <= r;
        do @(posedge clk); while (!in_ready);
        predict_downmix(l, r, res, count);
        if (typed)
        begin
            if (count == 2)
            begin
                res[0] = '{want_first, 1'b0};
                res[1] = '{want_second, 1'b1};
            end
            else
            begin
                res[0] = '{want_first, 1'b1};
            end
        end
        for (int i = 0; i < count; i++)
        begin
            pending_pcm.push_back(res[i]);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_pcm.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin : drive_out_ready
        int burst;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1)
            begin
                burst = $urandom_range(1, 5);
                out_ready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        pcm_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pcm.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual out_sample %0d last %0b",
                         $time, out_sample, last_of_frame);
                mismatches++;
            end
            else
            begin
                want = pending_pcm.pop_front();
                if (out_sample !== want.sample)
                begin
                    $display("%0t: out_sample expected %0d actual %0d",
                             $time, want.sample, out_sample);
                    mismatches++;
                end
                if (last_of_frame !== want.last)
                begin
                    $display("%0t: last_of_frame expected %0b actual %0b",
                             $time, want.last, last_of_frame);
                    mismatches++;
                end
            end
        end
    end

    // The run is stopped when no transaction of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        frame_row_t         rows [N_ROWS];
        logic [1:0]         mode;
        coef_kind_t         kind;
        int                 n_items;
        logic signed [15:0] l;
        logic signed [15:0] r;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        left_sample <= '0;
        right_sample <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        mismatches = 0;
        quiet_cycles = 0;
        idle_odds = 3;
        model_mode = MODE_LOWPASS;
        model_coef.s1_b1 = DEF_S1_B1;
        model_coef.s1_a1 = DEF_S1_A1;
        model_coef.s1_a2 = DEF_S1_A2;
        model_coef.s2_b1 = DEF_S2_B1;
        model_coef.s2_a1 = DEF_S2_A1;
        model_coef.s2_a2 = DEF_S2_A2;
        for (int i = 0; i < 2; i++)
        begin
            s1_x_hist[i] = '0;
            s1_y_hist[i] = '0;
            s2_y_hist[i] = '0;
        end

        rows = '{
            '{MODE_LOWPASS, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
            '{MODE_LOWPASS, 16'sh7FFF, 16'sh7FFF, 1'b0, 16'sd0, 16'sd0},
            '{MODE_LOWPASS, 16'sh8000, 16'sh8000, 1'b0, 16'sd0, 16'sd0},
            '{MODE_LOWPASS, 16'sh5555, 16'shAAAA, 1'b0, 16'sd0, 16'sd0},
            '{MODE_STEREO, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh7FFF, 16'sh8000},
            '{MODE_STEREO, -16'sd1, 16'sd0, 1'b1, -16'sd1, 16'sd0},
            '{MODE_STEREO, 16'sh5555, 16'shAAAA, 1'b1, 16'sh5555, 16'shAAAA},
            '{MODE_MONO, 16'sh7FFF, 16'sh7FFF, 1'b1, 16'sh7FFF, 16'sd0},
            '{MODE_MONO, 16'sh8000, 16'sh8000, 1'b1, 16'sh8000, 16'sd0},
            '{MODE_MONO, 16'sh7FFF, 16'sh8000, 1'b1, -16'sd1, 16'sd0},
            '{MODE_MONO, 16'sd1, 16'sd0, 1'b1, 16'sd1, 16'sd0},
            '{MODE_MONO, -16'sd1, 16'sd0, 1'b1, -16'sd1, 16'sd0},
            '{MODE_MONO, 16'sd3, 16'sd0, 1'b1, 16'sd2, 16'sd0},
            '{MODE_MONO, -16'sd3, 16'sd0, 1'b1, -16'sd2, 16'sd0},
            '{MODE_LOWPASS_ALIAS, 16'sd1000, 16'sd1000, 1'b0, 16'sd0, 16'sd0},
            '{MODE_LOWPASS_ALIAS, 16'sh8000, 16'sh7FFF, 1'b0, 16'sd0, 16'sd0},
            '{MODE_LOWPASS, 16'sd12345, -16'sd4321, 1'b0, 16'sd0, 16'sd0},
            '{MODE_LOWPASS, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
        begin
            if (rows[i].mode != model_mode)
            begin
                wait_idle();
                write_reg(CFG_NONE, $urandom());
                write_reg(CFG_MODE, {30'($urandom()), rows[i].mode});
                cfg_valid <= 1'b0;
            end
            send_frame(rows[i].l_pcm, rows[i].r_pcm, rows[i].typed,
                       rows[i].want_first, rows[i].want_second);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    mode = MODE_LOWPASS;
                    kind = COEF_RANDOM;
                end
                1:
                begin
                    mode = MODE_LOWPASS_ALIAS;
                    kind = COEF_MAX;
                end
                2:
                begin
                    mode = MODE_LOWPASS;
                    kind = COEF_MIN;
                end
                3:
                begin
                    mode = MODE_STEREO;
                    kind = COEF_ZERO;
                end
                4:
                begin
                    mode = MODE_LOWPASS;
                    kind = COEF_SMALL;
                end
                5:
                begin
                    mode = MODE_MONO;
                    kind = COEF_DEFAULT;
                end
                default:
                begin
                    if ($urandom_range(0, 9) < 3)
                    begin
                        mode = $urandom_range(0, 1) ? MODE_STEREO : MODE_MONO;
                    end
                    else
                    begin
                        mode = $urandom_range(0, 1) ? MODE_LOWPASS : MODE_LOWPASS_ALIAS;
                    end
                    kind = coef_kind_t'($urandom_range(0, 5));
                end
            endcase

            wait_idle();
            write_reg(CFG_S1_B1, pick_coef(kind, DEF_S1_B1));
            write_reg(CFG_S1_A1, pick_coef(kind, DEF_S1_A1));
            write_reg(CFG_S1_A2, pick_coef(kind, DEF_S1_A2));
            write_reg(CFG_S2_B1, pick_coef(kind, DEF_S2_B1));
            write_reg(CFG_S2_A1, pick_coef(kind, DEF_S2_A1));
            write_reg(CFG_S2_A2, pick_coef(kind, DEF_S2_A2));
            write_reg(CFG_NONE, $urandom());
            write_reg(CFG_MODE, {30'($urandom()), mode});
            cfg_valid <= 1'b0;

            if (ph == N_PHASES - 1)
            begin
                idle_odds = 0;
                n_items = 150;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: idle_odds = 0;
                    1: idle_odds = 2;
                    2: idle_odds = 4;
                    default: idle_odds = 8;
                endcase
                n_items = $urandom_range(80, 120);
            end

            for (int k = 0; k < n_items; k++)
            begin
                case ($urandom_range(0, 7))
                    0:
                    begin
                        l = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                        r = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    end
                    1:
                    begin
                        l = 16'($urandom_range(0, 64)) - 16'sd32;
                        r = 16'($urandom_range(0, 64)) - 16'sd32;
                    end
                    2:
                    begin
                        l = 16'($urandom());
                        r = l + 16'($urandom_range(0, 256)) - 16'sd128;
                    end
                    default:
                    begin
                        l = 16'($urandom());
                        r = 16'($urandom());
                    end
                endcase
                send_frame(l, r, 1'b0, 16'sd0, 16'sd0);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
